// ===== design/vdm_pkg.sv =====
`default_nettype none
package vdm_pkg;
   localparam int ElemW   = 16;
   localparam int SdsW    = 45;
   localparam int SpW     = 44;
   localparam int NsqW    = 43;
   localparam int OutW    = 46;
   localparam int RootW   = 23;
   localparam int QDepth  = 2;

   typedef enum logic [1:0] {
      MODE_L2SQ = 2'd0,
      MODE_L2   = 2'd1,
      MODE_DOT  = 2'd2,
      MODE_COS  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [SdsW-1:0] sds;
      logic [SpW-1:0]  sp;
      logic [NsqW-1:0] na;
      logic [NsqW-1:0] nb;
      mode_type        mode;
   } job_type;
endpackage
`default_nettype wire

// ===== design/vdm_front.sv =====
`default_nettype none
module vdm_front import vdm_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [ElemW-1:0] req_elem_a,
   input  wire logic signed [ElemW-1:0] req_elem_b,
   input  wire logic                    req_last,
   input  wire mode_type                mode,
   output logic                         job_valid,
   input  wire logic                    job_ready,
   output job_type                      job
);
   // product stage registers
   logic                  p_valid_ff, p_valid_in;
   logic                  p_last_ff;
   logic [2*ElemW:0]      p_dd_ff;
   logic signed [2*ElemW-1:0] p_ab_ff;
   logic [2*ElemW-1:0]    p_aa_ff, p_bb_ff;
   // accumulators
   logic [SdsW-1:0]       sds_ff, sds_in;
   logic signed [SpW-1:0] sp_ff, sp_in;
   logic [NsqW-1:0]       na_ff, na_in, nb_ff, nb_in;
   // queue
   job_type               q_ff [QDepth];
   logic [1:0]            q_cnt_ff, q_cnt_in;
   logic                  q_wr_ff, q_wr_in, q_rd_ff, q_rd_in;
   logic                  push, pop;
   logic signed [ElemW:0] d;
   logic [ElemW:0]        ud;
   logic [SdsW:0]         sds_sum;
   logic [NsqW:0]         na_sum, nb_sum;
   logic signed [SpW:0]   sp_sum;
   logic                  p_go;

   // the product stage may advance unless a last pair finds the queue full
   assign p_go      = !(p_valid_ff && p_last_ff && q_cnt_ff == 2'(QDepth));
   assign req_ready = p_go;
   assign push      = p_valid_ff && p_last_ff && p_go;
   assign pop       = job_valid && job_ready;
   assign job_valid = q_cnt_ff != 2'd0;
   assign job       = q_ff[q_rd_ff];

   assign d  = {req_elem_a[ElemW-1], req_elem_a} - {req_elem_b[ElemW-1], req_elem_b};
   assign ud = d[ElemW] ? (ElemW+1)'(-d) : d;

   // saturating sums
   always_comb begin
      sds_sum = {1'b0, sds_ff} + (SdsW+1)'(p_dd_ff);
      na_sum  = {1'b0, na_ff} + (NsqW+1)'(p_aa_ff);
      nb_sum  = {1'b0, nb_ff} + (NsqW+1)'(p_bb_ff);
      sp_sum  = {sp_ff[SpW-1], sp_ff} + (SpW+1)'(p_ab_ff);
      sds_in = sds_ff; na_in = na_ff; nb_in = nb_ff; sp_in = sp_ff;
      if (p_valid_ff && p_go) begin
         sds_in = sds_sum[SdsW] ? '1 : sds_sum[SdsW-1:0];
         na_in  = na_sum[NsqW] ? '1 : na_sum[NsqW-1:0];
         nb_in  = nb_sum[NsqW] ? '1 : nb_sum[NsqW-1:0];
         if (sp_sum[SpW] != sp_sum[SpW-1])
            sp_in = sp_sum[SpW] ? {1'b1, {(SpW-1){1'b0}}} : {1'b0, {(SpW-1){1'b1}}};
         else
            sp_in = sp_sum[SpW-1:0];
         if (p_last_ff) begin
            sds_in = '0; na_in = '0; nb_in = '0; sp_in = '0;
         end
      end
   end

   always_comb begin
      p_valid_in = p_go ? req_valid : p_valid_ff;
      q_wr_in    = push ? !q_wr_ff : q_wr_ff;
      q_rd_in    = pop ? !q_rd_ff : q_rd_ff;
      q_cnt_in   = q_cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         sds_ff <= '0; sp_ff <= '0; na_ff <= '0; nb_ff <= '0;
         q_cnt_ff <= '0; q_wr_ff <= 1'b0; q_rd_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         sds_ff <= sds_in; sp_ff <= sp_in; na_ff <= na_in; nb_ff <= nb_in;
         q_cnt_ff <= q_cnt_in; q_wr_ff <= q_wr_in; q_rd_ff <= q_rd_in;
      end
   end

   // capture products and the finished sums
   always_ff @(posedge clock) begin
      if (p_go && req_valid) begin
         p_last_ff <= req_last;
         p_dd_ff   <= (2*ElemW+1)'(ud) * (2*ElemW+1)'(ud);
         p_ab_ff   <= (2*ElemW)'(req_elem_a) * (2*ElemW)'(req_elem_b);
         p_aa_ff   <= (2*ElemW)'(req_elem_a) * (2*ElemW)'(req_elem_a);
         p_bb_ff   <= (2*ElemW)'(req_elem_b) * (2*ElemW)'(req_elem_b);
      end
      if (push) begin
         q_ff[q_wr_ff].sds  <= sds_sum[SdsW] ? '1 : sds_sum[SdsW-1:0];
         q_ff[q_wr_ff].na   <= na_sum[NsqW] ? '1 : na_sum[NsqW-1:0];
         q_ff[q_wr_ff].nb   <= nb_sum[NsqW] ? '1 : nb_sum[NsqW-1:0];
         q_ff[q_wr_ff].sp   <= (sp_sum[SpW] != sp_sum[SpW-1]) ?
            (sp_sum[SpW] ? {1'b1, {(SpW-1){1'b0}}} : {1'b0, {(SpW-1){1'b1}}}) :
            sp_sum[SpW-1:0];
         q_ff[q_wr_ff].mode <= mode;
      end
   end
endmodule
`default_nettype wire

// ===== design/vdm_back.sv =====
`default_nettype none
module vdm_back import vdm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  job_valid,
   output logic                       job_ready,
   input  wire job_type               job,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [OutW-1:0]     rsp_metric_value,
   output logic                       rsp_undefined_result
);
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_ROOT = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_FIN  = 7'b0010000,
      ST_OUT  = 7'b0100000,
      ST_SEL  = 7'b1000000
   } state_type;

   state_type          st_ff, st_in;
   job_type            j_ff;
   // isqrt on up to two operands at once: restoring, one result bit a step
   logic [2*RootW-1:0] r0v_ff, r1v_ff;
   logic [RootW-1:0]   r0_ff, r1_ff;
   logic [RootW:0]     rem0_ff, rem1_ff;
   logic [4:0]         cnt_ff;
   logic [2*RootW-1:0] den_ff;
   logic [2*RootW-1:0] rem_ff;
   logic [15:0]        quo_ff;
   logic               neg_ff;
   logic [OutW-1:0]    val_ff;
   logic               und_ff;
   logic [RootW+1:0]   t0, t1;
   logic [2*RootW:0]   dt;
   logic [SpW-1:0]     mag;

   assign job_ready = st_ff == ST_IDLE;
   assign rsp_valid = st_ff == ST_OUT;
   assign rsp_metric_value = val_ff;
   assign rsp_undefined_result = und_ff;

   always_comb begin
      t0 = {rem0_ff[RootW-1:0], r0v_ff[2*RootW-1 -: 2]} - {r0_ff, 2'b01};
      t1 = {rem1_ff[RootW-1:0], r1v_ff[2*RootW-1 -: 2]} - {r1_ff, 2'b01};
      dt = {1'b0, rem_ff} - {1'b0, den_ff};
      mag = j_ff.sp[SpW-1] ? SpW'(-j_ff.sp) : j_ff.sp;
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (job_valid) st_in = ST_SEL;
         ST_SEL:  st_in = (j_ff.mode == MODE_L2 || j_ff.mode == MODE_COS) ? ST_ROOT : ST_FIN;
         ST_ROOT: if (cnt_ff == 5'd0) st_in = (j_ff.mode == MODE_COS) ? ST_MUL : ST_FIN;
         ST_MUL:  st_in = (r0_ff == '0 || r1_ff == '0) ? ST_FIN : ST_DIV;
         ST_DIV:  if (cnt_ff == 5'd0) st_in = ST_FIN;
         ST_FIN:  st_in = ST_OUT;
         ST_OUT:  if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: j_ff <= job;
         ST_SEL: begin
            r0v_ff <= (j_ff.mode == MODE_COS) ? (2*RootW)'(j_ff.na) : (2*RootW)'(j_ff.sds);
            r1v_ff <= (2*RootW)'(j_ff.nb);
            r0_ff <= '0; r1_ff <= '0; rem0_ff <= '0; rem1_ff <= '0;
            cnt_ff <= 5'(RootW);
         end
         ST_ROOT: if (cnt_ff != 5'd0) begin
            cnt_ff <= cnt_ff - 5'd1;
            r0v_ff <= {r0v_ff[2*RootW-3:0], 2'b00};
            r1v_ff <= {r1v_ff[2*RootW-3:0], 2'b00};
            if (!t0[RootW+1]) begin
               rem0_ff <= t0[RootW:0];
               r0_ff   <= {r0_ff[RootW-2:0], 1'b1};
            end else begin
               rem0_ff <= {rem0_ff[RootW-2:0], r0v_ff[2*RootW-1 -: 2]};
               r0_ff   <= {r0_ff[RootW-2:0], 1'b0};
            end
            if (!t1[RootW+1]) begin
               rem1_ff <= t1[RootW:0];
               r1_ff   <= {r1_ff[RootW-2:0], 1'b1};
            end else begin
               rem1_ff <= {rem1_ff[RootW-2:0], r1v_ff[2*RootW-1 -: 2]};
               r1_ff   <= {r1_ff[RootW-2:0], 1'b0};
            end
         end
         ST_MUL: begin
            den_ff <= r0_ff * r1_ff;
            rem_ff <= (2*RootW)'(mag);
            quo_ff <= '0;
            neg_ff <= j_ff.sp[SpW-1];
            cnt_ff <= 5'd16;
         end
         ST_DIV: if (cnt_ff != 5'd0) begin
            // long division of the magnitude; the first bit set means the
            // quotient is out of Q1.15 range and is saturated later
            cnt_ff <= cnt_ff - 5'd1;
            if (!dt[2*RootW]) begin
               rem_ff <= {dt[2*RootW-2:0], 1'b0};
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[2*RootW-2:0], 1'b0};
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
         end
         ST_FIN: begin
            und_ff <= 1'b0;
            unique case (j_ff.mode)
               MODE_L2SQ: val_ff <= OutW'(j_ff.sds);
               MODE_L2:   val_ff <= OutW'(r0_ff);
               MODE_DOT:  val_ff <= OutW'(j_ff.sp) | {OutW{j_ff.sp[SpW-1]}} & ~OutW'({SpW{1'b1}});
               default: begin
                  if (r0_ff == '0 || r1_ff == '0) begin
                     und_ff <= 1'b1; val_ff <= '0;
                  end else if (neg_ff)
                     val_ff <= quo_ff[15] ? -OutW'(32768) : -OutW'(quo_ff);
                  else
                     val_ff <= quo_ff[15] ? OutW'(32767) : OutW'(quo_ff);
               end
            endcase
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ===== design/vector_distance_metric.sv =====
// Path: a vector passes the product register and job queue; the back part runs SEL,
// ROOT (modes 1, 3), MUL, DIV (mode 3; no DIV if a magnitude is zero), FIN, OUT.
// Throughput: one pair per cycle; the back part finishes one vector at a time and the
// input stalls while a last pair waits for a free slot in the two-entry queue.
// Reset: synchronous, active high; clears accumulators, queue and mode (squared L2).
`default_nettype none
module vector_distance_metric import vdm_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [ElemW-1:0] req_elem_a,
   input  wire logic signed [ElemW-1:0] req_elem_b,
   input  wire logic                    req_last,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [OutW-1:0]       rsp_metric_value,
   output logic                         rsp_undefined_result,
   input  wire logic                    csr_write_enable,
   input  wire logic [1:0]              csr_write_data
);
   mode_type mode_ff;
   logic     job_valid, job_ready;
   job_type  job;

   // hold the metric mode
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_L2SQ;
      else if (csr_write_enable) mode_ff <= mode_type'(csr_write_data);
   end

   vdm_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_elem_a, .req_elem_b, .req_last,
      .mode(mode_ff), .job_valid, .job_ready, .job
   );

   vdm_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .rsp_valid, .rsp_ready, .rsp_metric_value, .rsp_undefined_result
   );
endmodule
`default_nettype wire
